[src/avcd_pkg.sv]
// Package for the autoranging voltmeter with charlieplexed display.
// Holds widths, reciprocal constants, codes, pin tables and the font lookup.
// No dependencies.
package avcd_pkg;

	// Averaging and converter widths
	localparam int SAMPLES_PER_READING = 10;
	localparam int ADC_BITS            = 10;
	localparam int ADC_SAMPLE_W        = 10;
	localparam int CNT_W  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int SUM_W  = ADC_BITS + $clog2(SAMPLES_PER_READING);
	localparam int AVG_W  = ADC_BITS;
	localparam int SCALED_W = AVG_W + 1;
	localparam int RND_W  = (SCALED_W >= 11) ? SCALED_W + 1 : 12;
	localparam int VAL_W  = 8;

	// Reciprocals for the constant divisions (ceil(2^K / N))
	localparam int AVG_K  = SUM_W + 5;
	localparam int DIV5_K = AVG_W + 6;
	localparam int DIV10_K  = RND_W + 4;
	localparam int DIV100_K = RND_W + 7;
	localparam logic [AVG_K:0] AVG_RECIP =
		(AVG_K+1)'((2**AVG_K + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);
	localparam logic [DIV5_K-1:0] DIV5_RECIP = DIV5_K'((2**DIV5_K + 4) / 5);
	localparam logic [DIV10_K-1:0] DIV10_RECIP = DIV10_K'((2**DIV10_K + 9) / 10);
	localparam logic [DIV100_K-1:0] DIV100_RECIP = DIV100_K'((2**DIV100_K + 99) / 100);

	// Autorange limits
	localparam logic [RND_W-1:0] LIMIT_AS_IS    = RND_W'(199);
	localparam logic [RND_W-1:0] LIMIT_TENTHS   = RND_W'(1995);
	localparam logic [RND_W-1:0] HALF_TENTH     = RND_W'(5);
	localparam logic [RND_W-1:0] HALF_UNIT      = RND_W'(50);

	// Display
	localparam int LED_COUNT = 20;
	localparam int SLOT_W    = $clog2(LED_COUNT);
	localparam int PIN_COUNT = 5;
	localparam int PIN_W     = 3;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LED_COUNT - 1);

	localparam logic [PIN_W-1:0] ANODE_PIN [LED_COUNT] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1};
	localparam logic [PIN_W-1:0] CATHODE_PIN [LED_COUNT] = '{
		3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd3, 3'd4, 3'd0, 3'd1,
		3'd2, 3'd4, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2, 3'd3, 3'd4};

	// Configuration
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 64;
	localparam logic REG_FONT_LOW  = 1'b0;
	localparam logic REG_FONT_HIGH = 1'b1;
	localparam logic [63:0] FONT_LOW_RESET  = 64'd535366328472370751;
	localparam logic [15:0] FONT_HIGH_RESET = 16'd28543;

	// Codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;
	localparam logic KIND_PINS    = 1'b0;
	localparam logic KIND_READING = 1'b1;

	typedef enum logic [1:0] {
		POINT_FIRST  = 2'd1,
		POINT_SECOND = 2'd2,
		POINT_THIRD  = 2'd3
	} point_t;

	// Segment byte of one digit from the two font registers
	function automatic logic [7:0] font_of(input logic [3:0] digit,
	                                       input logic [63:0] lo,
	                                       input logic [15:0] hi);
		logic [7:0] f;
		unique case (digit)
			4'd0: f = lo[7:0];
			4'd1: f = lo[15:8];
			4'd2: f = lo[23:16];
			4'd3: f = lo[31:24];
			4'd4: f = lo[39:32];
			4'd5: f = lo[47:40];
			4'd6: f = lo[55:48];
			4'd7: f = lo[63:56];
			4'd8: f = hi[7:0];
			4'd9: f = hi[15:8];
			default: f = 8'd0;
		endcase
		return f;
	endfunction

endpackage

[src/avcd_if.sv]
// Channel interfaces of the voltmeter block: request items in, result items out.
// Depends on avcd_pkg for field widths.
interface avcd_req_if
	import avcd_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [ADC_SAMPLE_W-1:0] adc_sample;

	modport source (output valid, req_type, adc_sample, input ready);
	modport sink   (input valid, req_type, adc_sample, output ready);
endinterface

interface avcd_rsp_if
	import avcd_pkg::*;
	();
	logic           valid;
	logic           ready;
	logic           result_kind;
	logic [4:0]     pin_level;
	logic [4:0]     pin_dir;
	logic [10:0]    reading_scaled;
	logic [3:0]     hundreds_digit;
	logic [3:0]     tens_digit;
	logic [3:0]     units_digit;
	logic [1:0]     point_position;

	modport source (output valid, result_kind, pin_level, pin_dir, reading_scaled,
		hundreds_digit, tens_digit, units_digit, point_position, input ready);
	modport sink   (input valid, result_kind, pin_level, pin_dir, reading_scaled,
		hundreds_digit, tens_digit, units_digit, point_position, output ready);
endinterface

[src/autorange_voltmeter_charlieplex_drive.sv]
// Autoranging voltmeter with charlieplexed 20-LED drive: top level.
// An accepted item moves through the stage registers in order into the output register.
// Throughput: one item per cycle; ready drops only when all five stages hold
// items and the output is stalled. Samples that do not close a group leave no item.
// Reset (arst_n low, asynchronous): pipeline empty, sum/index/scan slot zero,
// all LEDs off, font registers at their default glyphs.
module autorange_voltmeter_charlieplex_drive
	import avcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	avcd_req_if.sink              req,
	avcd_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	// ---------------------------------------------------------------
	// Configuration registers. Only paddr[3] selects a register.
	// ---------------------------------------------------------------
	logic [63:0] font_low_q;
	logic [15:0] font_high_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[3] == REG_FONT_HIGH) ? {48'd0, font_high_q} : font_low_q;

	// ---------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its content moves on.
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic free_s1, free_s2, free_s3, free_s4, free_s5;

	assign free_s5 = !valid_s5 || rsp.ready;
	assign free_s4 = !valid_s4 || free_s5;
	assign free_s3 = !valid_s3 || free_s4;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;
	assign req.ready = free_s1;

	logic accept;
	assign accept = req.valid && req.ready;

	// ---------------------------------------------------------------
	// Accept stage: accumulate samples, advance the scan slot on ticks.
	// ---------------------------------------------------------------
	logic [SUM_W-1:0]    sample_sum_q;
	logic [CNT_W-1:0]    sample_index_q;
	logic [SLOT_W-1:0]   scan_slot_q;
	logic [ADC_BITS-1:0] sample_used;
	logic [SUM_W-1:0]    sum_next;
	logic                group_done;
	logic                is_tick;

	assign is_tick     = (req.req_type == REQ_TICK);
	assign sample_used = ADC_BITS'(req.adc_sample);
	assign sum_next    = sample_sum_q + SUM_W'(sample_used);
	assign group_done  = (sample_index_q == CNT_W'(SAMPLES_PER_READING - 1));

	// Stage payloads
	logic              kind_s1, kind_s2, kind_s3, kind_s4;
	logic [SLOT_W-1:0] slot_s1, slot_s2, slot_s3, slot_s4;
	logic [SUM_W-1:0]  sum_s1;
	logic [AVG_W-1:0]  avg_s2;
	logic [SCALED_W-1:0] scaled_s3, scaled_s4;
	logic [VAL_W-1:0]  val_s4;
	point_t            pt_s4;

	// ---------------------------------------------------------------
	// Stage 2: average = sum / SAMPLES_PER_READING by reciprocal multiply.
	// ---------------------------------------------------------------
	logic [SUM_W+AVG_K:0] avg_prod;
	logic [AVG_W-1:0]     avg_next;

	assign avg_prod = (SUM_W+AVG_K+1)'(sum_s1) * (SUM_W+AVG_K+1)'(AVG_RECIP);
	assign avg_next = avg_prod[AVG_K +: AVG_W];

	// ---------------------------------------------------------------
	// Stage 3: scaled = floor(avg * 49 / 40) = floor(floor(avg*49/8) / 5).
	// ---------------------------------------------------------------
	logic [AVG_W+5:0]          p49;
	logic [AVG_W+2:0]          p8;
	logic [AVG_W+2+DIV5_K:0]   sc_prod;
	logic [SCALED_W-1:0]       scaled_next;

	assign p49 = ((AVG_W+6)'(avg_s2) << 5) + ((AVG_W+6)'(avg_s2) << 4) + (AVG_W+6)'(avg_s2);
	assign p8  = p49[AVG_W+5:3];
	assign sc_prod = (AVG_W+3+DIV5_K)'(p8) * (AVG_W+3+DIV5_K)'(DIV5_RECIP);
	assign scaled_next = sc_prod[DIV5_K +: SCALED_W];

	// ---------------------------------------------------------------
	// Stage 4: autorange. Rounding half-up is floor((v + half) / step).
	// The shown value always stays below 200.
	// ---------------------------------------------------------------
	logic [RND_W-1:0]          v_ext;
	logic [RND_W+DIV10_K-1:0]  q10_prod;
	logic [RND_W+DIV100_K-1:0] q100_prod;
	logic [VAL_W-1:0]          q10, q100;
	logic [VAL_W-1:0]          val_next;
	point_t                    pt_next;

	assign v_ext     = RND_W'(scaled_s3);
	assign q10_prod  = (RND_W+DIV10_K)'(v_ext + HALF_TENTH) * (RND_W+DIV10_K)'(DIV10_RECIP);
	assign q100_prod = (RND_W+DIV100_K)'(v_ext + HALF_UNIT) *
		(RND_W+DIV100_K)'(DIV100_RECIP);
	assign q10  = q10_prod[DIV10_K +: VAL_W];
	assign q100 = q100_prod[DIV100_K +: VAL_W];

	always_comb begin
		priority if (v_ext <= LIMIT_AS_IS) begin
			pt_next  = POINT_FIRST;
			val_next = v_ext[VAL_W-1:0];
		end else if (v_ext < LIMIT_TENTHS) begin
			pt_next  = POINT_SECOND;
			val_next = q10;
		end else begin
			pt_next  = POINT_THIRD;
			val_next = q100;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5 (output register): digits, LED pattern, pin drive.
	// ---------------------------------------------------------------
	logic [LED_COUNT-1:0] led_q;
	logic [LED_COUNT-1:0] led_next;
	logic                 d1;
	logic [6:0]           rem;
	logic [14:0]          d2_prod;
	logic [3:0]           d2, d3;
	logic [7:0]           font_tens, font_units;

	assign d1      = (val_s4 >= VAL_W'(100));
	assign rem     = d1 ? 7'(val_s4 - VAL_W'(100)) : val_s4[6:0];
	assign d2_prod = 15'(rem) * 15'd205;
	assign d2      = d2_prod[14:11];
	assign d3      = 4'(rem - 7'(d2) * 7'd10);
	assign font_tens  = font_of(d2, font_low_q, font_high_q);
	assign font_units = font_of(d3, font_low_q, font_high_q);

	always_comb begin
		led_next        = '0;
		led_next[1]     = d1;
		led_next[2]     = d1;
		led_next[3]     = (pt_s4 == POINT_FIRST);
		led_next[11:4]  = font_tens;
		led_next[19:12] = font_units;
		// Decimal points override the last segment of each digit
		led_next[11]    = (pt_s4 == POINT_SECOND);
		led_next[19]    = (pt_s4 == POINT_THIRD);
	end

	// Anode high, cathode low when lit, high when dark; others released
	logic [PIN_W-1:0]     anode, cathode;
	logic                 led_off;
	logic [PIN_COUNT-1:0] level_next, dir_next;

	assign anode      = ANODE_PIN[slot_s4];
	assign cathode    = CATHODE_PIN[slot_s4];
	assign led_off    = !led_q[slot_s4];
	assign level_next = (PIN_COUNT'(1) << anode) | (PIN_COUNT'(led_off) << cathode);
	assign dir_next   = (PIN_COUNT'(1) << anode) | (PIN_COUNT'(1) << cathode);

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_low_q     <= FONT_LOW_RESET;
			font_high_q    <= FONT_HIGH_RESET;
			sample_sum_q   <= '0;
			sample_index_q <= '0;
			scan_slot_q    <= '0;
			led_q          <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			valid_s5       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[3] == REG_FONT_HIGH) begin
					font_high_q <= pwdata[15:0];
				end else begin
					font_low_q <= pwdata;
				end
			end
			if (accept) begin
				if (is_tick) begin
					scan_slot_q <= (scan_slot_q == LAST_SLOT) ? '0 : scan_slot_q + SLOT_W'(1);
				end else if (group_done) begin
					sample_sum_q   <= '0;
					sample_index_q <= '0;
				end else begin
					sample_sum_q   <= sum_next;
					sample_index_q <= sample_index_q + CNT_W'(1);
				end
			end
			if (free_s1) valid_s1 <= accept && (is_tick || group_done);
			if (free_s2) valid_s2 <= valid_s1;
			if (free_s3) valid_s3 <= valid_s2;
			if (free_s4) valid_s4 <= valid_s3;
			if (free_s5) valid_s5 <= valid_s4;
			// Latch the new pattern as the reading enters the output register
			if (free_s5 && valid_s4 && kind_s4 == KIND_READING) led_q <= led_next;
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (free_s1) begin
			kind_s1 <= is_tick ? KIND_PINS : KIND_READING;
			slot_s1 <= scan_slot_q;
			sum_s1  <= sum_next;
		end
		if (free_s2) begin
			kind_s2 <= kind_s1;
			slot_s2 <= slot_s1;
			avg_s2  <= avg_next;
		end
		if (free_s3) begin
			kind_s3   <= kind_s2;
			slot_s3   <= slot_s2;
			scaled_s3 <= scaled_next;
		end
		if (free_s4) begin
			kind_s4   <= kind_s3;
			slot_s4   <= slot_s3;
			scaled_s4 <= scaled_s3;
			val_s4    <= val_next;
			pt_s4     <= pt_next;
		end
		if (free_s5) begin
			rsp.result_kind <= kind_s4;
			if (kind_s4 == KIND_READING) begin
				rsp.pin_level      <= '0;
				rsp.pin_dir        <= '0;
				rsp.reading_scaled <= 11'(scaled_s4);
				rsp.hundreds_digit <= 4'(d1);
				rsp.tens_digit     <= d2;
				rsp.units_digit    <= d3;
				rsp.point_position <= pt_s4;
			end else begin
				rsp.pin_level      <= level_next;
				rsp.pin_dir        <= dir_next;
				rsp.reading_scaled <= '0;
				rsp.hundreds_digit <= '0;
				rsp.tens_digit     <= '0;
				rsp.units_digit    <= '0;
				rsp.point_position <= '0;
			end
		end
	end

	assign rsp.valid = valid_s5;

endmodule

[tb/sv/autorange_voltmeter_charlieplex_drive_tb.sv]
`timescale 1ns / 1ps
// Testbench for the autoranging voltmeter with charlieplexed LED drive.
// A scoreboard class predicts every reading and pin drive and checks each result item.
// Depends on avcd_pkg, the avcd channel interfaces and the block's top level.
module autorange_voltmeter_charlieplex_drive_tb
	import avcd_pkg::*;
();

	localparam int CLOCK_LIMIT    = 400000; // generous cycle cap for the whole run
	localparam int LONG_HOLD      = 120;    // cycles the receiver holds off once
	localparam int HOLD_AFTER     = 100;    // results to see before that hold
	localparam int SETTLE_CYCLES  = 8;      // pipeline depth plus margin
	localparam int ITEMS_PER_PASS = 255;

	// One result item as the block presents it
	typedef struct packed {
		logic        kind;
		logic [4:0]  level;
		logic [4:0]  dir;
		logic [10:0] scaled;
		logic [3:0]  hundreds;
		logic [3:0]  tens;
		logic [3:0]  units;
		logic [1:0]  point;
	} drive_result_t;

	// Voltmeter scoreboard: its own copy of the fonts, the sample accumulator,
	// the latched LED pattern and the scan slot, plus the results still due.
	class display_scoreboard;
		logic [63:0]          font_low;
		logic [15:0]          font_high;
		int unsigned          sample_total;
		int unsigned          samples_taken;
		logic [LED_COUNT-1:0] led_on;
		int unsigned          slot;
		drive_result_t        due_results[$];
		int unsigned          mismatches;

		function new();
			font_low      = FONT_LOW_RESET;
			font_high     = FONT_HIGH_RESET;
			sample_total  = 0;
			samples_taken = 0;
			led_on        = '0;
			slot          = 0;
			mismatches    = 0;
		endfunction

		function void write_reg(logic idx, logic [63:0] value);
			if (idx == REG_FONT_LOW) begin
				font_low = value;
			end else begin
				font_high = value[15:0];
			end
		endfunction

		function logic [7:0] glyph(int unsigned digit);
			if (digit < 8)
				return font_low[8*digit +: 8];
			if (digit < 10)
				return font_high[8*(digit-8) +: 8];
			return 8'd0;
		endfunction

		// Advance the voltmeter by one accepted item; queue the result it causes
		function void note_request(logic kind, logic [ADC_SAMPLE_W-1:0] sample);
			drive_result_t r;
			int unsigned   s;
			int unsigned   avg;
			int unsigned   scaled;
			int unsigned   v;
			int unsigned   d1;
			int unsigned   d2;
			int unsigned   d3;
			logic [2:0]    a;
			logic [2:0]    c;
			logic [7:0]    f2;
			logic [7:0]    f3;
			point_t        pt;
			r = '0;
			if (kind == REQ_TICK) begin
				s = (slot < LED_COUNT) ? slot : 0;
				a = ANODE_PIN[s];
				c = CATHODE_PIN[s];
				r.kind  = KIND_PINS;
				// cathode pulled low only when the LED is lit
				r.level = (5'd1 << a) | (led_on[s] ? 5'd0 : (5'd1 << c));
				r.dir   = (5'd1 << a) | (5'd1 << c);
				slot = (s + 1 >= LED_COUNT) ? 0 : s + 1;
				due_results.push_back(r);
				return;
			end
			sample_total += int'(sample) & ((1 << ADC_BITS) - 1);
			samples_taken++;
			if (samples_taken < SAMPLES_PER_READING)
				return;
			avg    = sample_total / SAMPLES_PER_READING;
			scaled = (avg * 49) / 40;
			sample_total  = 0;
			samples_taken = 0;
			v = scaled;
			if (v <= 199) begin
				pt = POINT_FIRST;
			end else if (v < 1995) begin
				if (v % 10 >= 5)
					v += 10;
				v  = v / 10;
				pt = POINT_SECOND;
			end else begin
				if (v % 100 >= 50)
					v += 100;
				v  = v / 100;
				pt = POINT_THIRD;
			end
			d1 = (v / 100) % 10;
			d2 = (v % 100) / 10;
			d3 = v % 10;
			f2 = glyph(d2);
			f3 = glyph(d3);
			led_on[0] = 1'b0; // minus sign stays dark
			led_on[1] = d1[0];
			led_on[2] = d1[0];
			led_on[3] = (pt == POINT_FIRST);
			for (int i = 0; i < 8; i++) begin
				led_on[4+i]  = f2[i];
				led_on[12+i] = f3[i];
			end
			led_on[11] = (pt == POINT_SECOND);
			led_on[19] = (pt == POINT_THIRD);
			r.kind     = KIND_READING;
			r.scaled   = 11'(scaled);
			r.hundreds = 4'(d1);
			r.tens     = 4'(d2);
			r.units    = 4'(d3);
			r.point    = pt;
			due_results.push_back(r);
		endfunction

		function string show(drive_result_t r);
			return $sformatf("kind=%0d lvl=%05b dir=%05b scaled=%0d digits=%0d%0d%0d pt=%0d",
				r.kind, r.level, r.dir, r.scaled, r.hundreds, r.tens, r.units, r.point);
		endfunction

		function void check_result(drive_result_t got);
			drive_result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: %s", show(got));
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	avcd_req_if req_ch ();
	avcd_rsp_if rsp_ch ();

	display_scoreboard sb;
	bit                idling_on;    // random stalls on both channels
	int unsigned       results_seen;
	int unsigned       cycle_count;

	autorange_voltmeter_charlieplex_drive dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CLOCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Check every result item at the edge where it is taken
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen <= results_seen + 1;
			sb.check_result('{rsp_ch.result_kind, rsp_ch.pin_level, rsp_ch.pin_dir,
				rsp_ch.reading_scaled, rsp_ch.hundreds_digit, rsp_ch.tens_digit,
				rsp_ch.units_digit, rsp_ch.point_position});
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so the
	// pipeline fills and the block has to drop ready on its input.
	initial begin
		bit long_hold_done;
		long_hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one item and hold it until the block takes it
	task automatic offer_request(logic kind, logic [ADC_SAMPLE_W-1:0] sample);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.adc_sample <= sample;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, sample);
	endtask

	// Register write with a setup phase and an access phase; the block takes it on the access cycle
	task automatic write_font(logic idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(idx) << 3;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	// Drop valid, wait for every due result, then let the pipeline settle
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mix of scan ticks and sample groups; each group clusters around a
	// target average, biased toward the range edges and the point-1 limit.
	task automatic run_random(int count);
		int unsigned target;
		int          n;
		target = 0;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 45) begin
				offer_request(REQ_TICK, ADC_SAMPLE_W'($urandom));
			end else begin
				if (sb.samples_taken == 0) begin
					case ($urandom_range(0, 5))
						0: target = $urandom_range(160, 167);
						1: target = $urandom_range(0, 3);
						2: target = $urandom_range(1020, 1023);
						default: target = $urandom_range(0, 1023);
					endcase
				end
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(0, 1023);
				end else begin
					n = int'(target) + int'($urandom_range(0, 6)) - 3;
					if (n < 0)
						n = 0;
					if (n > 1023)
						n = 1023;
				end
				offer_request(REQ_SAMPLE, ADC_SAMPLE_W'(n));
			end
		end
	endtask

	initial begin
		sb = new();
		idling_on    = 1'b1;
		results_seen = 0;
		cycle_count  = 0;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_SAMPLE;
		req_ch.adc_sample <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale group with the reset fonts, a few ticks,
		// then a group averaging right at the point-1 limit, more ticks.
		repeat (10) offer_request(REQ_SAMPLE, 10'd1023);
		repeat (3) offer_request(REQ_TICK, 10'd0);
		for (int k = 0; k < 10; k++)
			offer_request(REQ_SAMPLE, k[0] ? 10'd326 : 10'd0);
		repeat (2) offer_request(REQ_TICK, 10'd1023);

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain_block();
				case (p)
					1: begin
						write_font(REG_FONT_LOW, '1);
						write_font(REG_FONT_HIGH, 64'hFFFF);
					end
					2: begin
						write_font(REG_FONT_LOW, '0);
						write_font(REG_FONT_HIGH, '0);
					end
					default: begin
						write_font(REG_FONT_LOW, {$urandom, $urandom});
						write_font(REG_FONT_HIGH, 64'($urandom_range(0, 65535)));
					end
				endcase
			end
			// quiet pass in the middle, and none in the last part
			idling_on = (p != 2 && p != 5);
			run_random(ITEMS_PER_PASS);
		end

		drain_block();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
src/avcd_pkg.sv
src/avcd_if.sv
src/autorange_voltmeter_charlieplex_drive.sv
tb/sv/autorange_voltmeter_charlieplex_drive_tb.sv
